// ===== src/sdr_pkg.sv =====
// Shared item and result types for the stream duplicate remover.
`default_nettype none

package sdr_pkg;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               is_new;
		logic [7:0]         position;
		logic [8:0]         distinct_count;
		logic               overflow;
		logic               last_out;
	} result_t;

endpackage

`default_nettype wire

// ===== src/stream_duplicate_remover.sv =====
// Top level of the stream duplicate remover: scan sequencer and result register.
//
//  channel   valid          stall          payload
//  item      item_valid     item_stall     item   (value, last)
//  result    result_valid   result_stall   result (value_out .. last_out)
//
// An item that matches no stored value passes through these steps: accept, one read
// of the table RAM per stored entry through the single read port, the registered
// read data, the final compare and the hand-off. A match at entry j ends the scan
// early.
// Reset clears the count and the sequencer; the table needs no clearing.
// A stalled result waits in the output register; the next item is accepted
// and scanned meanwhile, and its result waits until the register frees.
`default_nettype none

module stream_duplicate_remover
	import sdr_pkg::*;
#(
	parameter int MAX_ITEMS = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	logic    res_valid;
	logic    res_take;
	result_t res;
	logic    out_free;
	logic    out_valid_q;
	result_t out_q;

	sdr_scan #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign out_free = !out_valid_q || !result_stall;
	assign res_take = res_valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== src/sdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/sdr_scan.sv =====
// Sequencer and shared comparator that scan the table of distinct values.
`default_nettype none

module sdr_scan
	import sdr_pkg::*;
#(
	parameter int MAX_ITEMS = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         res_valid,
	input  wire logic    res_take,
	output result_t      res
);

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             cmp_vld_q;
	logic [IDX_W-1:0] cmp_idx_q;
	item_t            item_q;
	result_t          res_q;

	logic             item_acc;
	logic             issue;
	logic             hit;
	logic             miss;
	logic             room;
	logic             ram_we;
	logic [IDX_W-1:0] raddr;
	logic [31:0]      rdata;
	logic [CNT_W-1:0] new_cnt;
	logic [IDX_W-1:0] new_pos;
	logic [IDX_W+7:0] pos_w;
	logic [CNT_W+8:0] cnt_w;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;

	assign issue = (idx_q < cnt_q);
	assign hit   = (state_q == ST_SCAN) && cmp_vld_q && (rdata == item_q.value);
	assign miss  = (state_q == ST_SCAN) && !cmp_vld_q && !issue;
	assign room  = (cnt_q < CNT_W'(MAX_ITEMS));
	assign ram_we = miss && room;
	assign raddr  = idx_q[IDX_W-1:0];

	always_comb begin
		new_cnt = cnt_q;
		new_pos = '0;
		if (hit) begin
			new_pos = cmp_idx_q;
		end else if (ram_we) begin
			new_pos = cnt_q[IDX_W-1:0];
			new_cnt = cnt_q + CNT_W'(1);
		end
	end

	assign pos_w = {8'b0, new_pos};
	assign cnt_w = {9'b0, new_cnt};

	sdr_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ITEMS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata(item_q.value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit || miss) begin
						cnt_q     <= item_q.last ? '0 : new_cnt;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_FIN;
					end else begin
						cmp_vld_q <= issue;
						idx_q     <= idx_q + CNT_W'(issue);
					end
				end
				ST_FIN: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_q <= item;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_q <= idx_q[IDX_W-1:0];
		end
		if (hit || miss) begin
			res_q.value_out      <= item_q.value;
			res_q.is_new         <= ram_we;
			res_q.position       <= pos_w[7:0];
			res_q.distinct_count <= cnt_w[8:0];
			res_q.overflow       <= miss && !room;
			res_q.last_out       <= item_q.last;
		end
	end

	assign res_valid = (state_q == ST_FIN);
	assign res       = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("stored count above table depth");

	a_acc_scan: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> (state_q == ST_SCAN) && !cmp_vld_q)
		else $error("scan did not start after item");

	a_ovf_new: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.overflow && res.is_new))
		else $error("item both new and overflowed");

	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(hit || miss) && item_q.last |=> cnt_q == '0)
		else $error("count not cleared after last item");

endmodule

`default_nettype wire
